// File: design/itf_pkg.sv
// Shared types, widths and character constants of the integer to text formatter.
package itf_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int MAX_PAD_DEF    = 64;

    localparam int VALUE_W     = 64;
    localparam int PAD_IN_W    = 7;
    localparam int KIND_W      = 2;
    localparam int CHAR_W      = 7;
    localparam int TDATA_IN_W  = 72;
    localparam int TDATA_OUT_W = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_SDEC = 2'd0,
        KIND_UDEC = 2'd1,
        KIND_HEX  = 2'd2,
        KIND_BIN  = 2'd3
    } t_kind;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;

    localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        return DIGIT_CHARS[d];
    endfunction

endpackage

// File: design/integer_to_text_formatter_unit.sv
// Top level of the integer to text formatter: front end, command queue and conversion engine.
//
// Each input beat carries a kind in tuser (signed decimal, unsigned decimal, lowercase hex,
// binary), and a value plus hex pad width in tdata; the unit answers with one output beat per
// ASCII character, most significant first, tlast on the final one. Signed decimal prints '-'
// and the magnitude for a set sign bit, hex is zero-padded on the left to the pad width
// (clamped to MAX_PAD), and a zero value always prints at least "0". Only the low VALUE_BITS
// bits of the value count. A two-entry queue behind the front end takes further values while
// the engine works, so the input side stalls only when the queue is full. Values are worked
// one at a time in the engine: it takes the command, runs the shift-add-3 double-dabble loop
// for decimal kinds, drops leading zero digits (keeping at least one), then puts out the sign,
// the pad zeros and the digits, one character at a time while the output is taken. The output
// is a registered stage, so the engine can start on the next value while the final character
// of the previous one waits.
module integer_to_text_formatter_unit #(
    parameter int VALUE_BITS = itf_pkg::VALUE_BITS_DEF,
    parameter int MAX_PAD    = itf_pkg::MAX_PAD_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata: value [63:0], pad_width [70:64], zero [71]
    input  logic [itf_pkg::TDATA_IN_W-1:0]  i_s_tdata,
    // tuser: kind [1:0]
    input  logic [itf_pkg::KIND_W-1:0]      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tdata: text_char [6:0], zero [7]
    output logic [itf_pkg::TDATA_OUT_W-1:0] o_m_tdata,
    output logic                            o_m_tlast
);
    import itf_pkg::*;

    localparam int PAD_W   = $clog2(MAX_PAD + 1);
    localparam int ENTRY_W = VALUE_BITS + KIND_W + 1 + PAD_W;

    logic               push;
    logic               full;
    logic               pop;
    logic               empty;
    logic [ENTRY_W-1:0] entry_in;
    logic [ENTRY_W-1:0] entry_out;

    // classify on the way in: sign split, mask, pad clamp
    itf_front #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_PAD    (MAX_PAD),
        .PAD_W      (PAD_W),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_push     (push),
        .i_full     (full),
        .o_entry    (entry_in)
    );

    // decouples input acceptance from the long conversion
    itf_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (entry_out),
        .o_empty (empty)
    );

    // digit generation and character output
    itf_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_PAD    (MAX_PAD),
        .PAD_W      (PAD_W),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .o_pop      (pop),
        .i_entry    (entry_out),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// File: design/itf_front.sv
// Front end: takes input beats, masks the value, splits sign and magnitude, clamps the pad.
module itf_front #(
    parameter int VALUE_BITS = itf_pkg::VALUE_BITS_DEF,
    parameter int MAX_PAD    = itf_pkg::MAX_PAD_DEF,
    parameter int PAD_W      = $clog2(MAX_PAD + 1),
    parameter int ENTRY_W    = VALUE_BITS + itf_pkg::KIND_W + 1 + PAD_W
) (
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [itf_pkg::TDATA_IN_W-1:0] i_s_tdata,
    input  logic [itf_pkg::KIND_W-1:0]    i_s_tuser,
    output logic                          o_push,
    input  logic                          i_full,
    output logic [ENTRY_W-1:0]            o_entry
);
    import itf_pkg::*;

    t_kind                 kind;
    logic [VALUE_BITS-1:0] val;
    logic [VALUE_BITS-1:0] mag;
    logic [PAD_IN_W-1:0]   pad_in;
    logic [PAD_W-1:0]      pad_sat;
    logic                  neg;

    assign kind   = t_kind'(i_s_tuser);
    assign val    = i_s_tdata[VALUE_BITS-1:0];
    assign pad_in = i_s_tdata[VALUE_W +: PAD_IN_W];

    // two's complement magnitude; the most negative value comes out exact
    assign neg = (kind == KIND_SDEC) && val[VALUE_BITS-1];
    assign mag = neg ? (~val + VALUE_BITS'(1)) : val;

    always_comb begin
        if (kind != KIND_HEX) begin
            pad_sat = '0;
        end else if (pad_in > PAD_IN_W'(MAX_PAD)) begin
            pad_sat = PAD_W'(MAX_PAD);
        end else begin
            pad_sat = PAD_W'(pad_in);
        end
    end

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;
    assign o_entry    = {pad_sat, neg, kind, mag};

endmodule

// File: design/itf_queue.sv
// Short command queue between front end and conversion engine.
module itf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import itf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slot[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

// File: design/itf_back.sv
// Conversion engine: double-dabble for decimal, leading-zero skip, pad, sign and character output.
module itf_back #(
    parameter int VALUE_BITS = itf_pkg::VALUE_BITS_DEF,
    parameter int MAX_PAD    = itf_pkg::MAX_PAD_DEF,
    parameter int PAD_W      = $clog2(MAX_PAD + 1),
    parameter int ENTRY_W    = VALUE_BITS + itf_pkg::KIND_W + 1 + PAD_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_empty,
    output logic                            o_pop,
    input  logic [ENTRY_W-1:0]              i_entry,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [itf_pkg::TDATA_OUT_W-1:0] o_m_tdata,
    output logic                            o_m_tlast
);
    import itf_pkg::*;

    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int DIG_W      = 4 * DEC_DIGITS;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int HEX_W      = 4 * HEX_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int CMP_W      = (CNT_W > PAD_W) ? CNT_W : PAD_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_CONV = 6'b000010,
        ST_SKIP = 6'b000100,
        ST_SIGN = 6'b001000,
        ST_PAD  = 6'b010000,
        ST_EMIT = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [DIG_W-1:0]      r_dig, n_dig;
    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [PAD_W-1:0]      r_pad, n_pad;
    logic                  r_neg, n_neg;
    logic                  r_bin_mode, n_bin_mode;
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]     r_out_char, n_out_char;
    logic                  r_out_last, n_out_last;

    logic [VALUE_BITS-1:0] e_mag;
    t_kind                 e_kind;
    logic                  e_neg;
    logic [PAD_W-1:0]      e_pad;

    logic [DIG_W-1:0]      dab;
    logic [3:0]            top;
    logic [DIG_W-1:0]      dig_shift;
    logic [PAD_W-1:0]      gap;
    logic                  slot_free;
    logic                  emit;
    logic                  emit_last;
    logic [CHAR_W-1:0]     emit_char;

    assign e_mag  = i_entry[VALUE_BITS-1:0];
    assign e_kind = t_kind'(i_entry[VALUE_BITS +: KIND_W]);
    assign e_neg  = i_entry[VALUE_BITS + KIND_W];
    assign e_pad  = i_entry[ENTRY_W-1 -: PAD_W];

    assign slot_free = !r_out_valid || i_m_tready;
    assign top       = r_bin_mode ? {3'b000, r_dig[DIG_W-1]} : r_dig[DIG_W-1 -: 4];
    assign dig_shift = r_bin_mode ? (r_dig << 1) : (r_dig << 4);

    // add-3 correction on every BCD digit
    always_comb begin
        logic [3:0] nib;
        dab = '0;
        for (int i = 0; i < DEC_DIGITS; i++) begin
            nib = r_dig[i*4 +: 4];
            dab[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
        end
    end

    // leading pad zeros still owed once the digit count is known
    always_comb begin
        logic [CMP_W-1:0] pad_ext;
        logic [CMP_W-1:0] cnt_ext;
        pad_ext = CMP_W'(r_pad);
        cnt_ext = CMP_W'(r_cnt);
        gap     = (pad_ext > cnt_ext) ? PAD_W'(pad_ext - cnt_ext) : '0;
    end

    always_comb begin
        n_state    = r_state;
        n_dig      = r_dig;
        n_bin      = r_bin;
        n_cnt      = r_cnt;
        n_pad      = r_pad;
        n_neg      = r_neg;
        n_bin_mode = r_bin_mode;
        o_pop      = 1'b0;
        emit       = 1'b0;
        emit_last  = 1'b0;
        emit_char  = CHAR_ZERO;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop      = 1'b1;
                    n_neg      = e_neg;
                    n_pad      = e_pad;
                    n_bin_mode = (e_kind == KIND_BIN);
                    case (e_kind)
                        KIND_SDEC, KIND_UDEC: begin
                            n_bin   = e_mag;
                            n_dig   = '0;
                            n_cnt   = CNT_W'(VALUE_BITS);
                            n_state = ST_CONV;
                        end
                        KIND_HEX: begin
                            n_dig   = DIG_W'(e_mag) << (DIG_W - HEX_W);
                            n_cnt   = CNT_W'(HEX_DIGITS);
                            n_state = ST_SKIP;
                        end
                        default: begin
                            n_dig   = DIG_W'(e_mag) << (DIG_W - VALUE_BITS);
                            n_cnt   = CNT_W'(VALUE_BITS);
                            n_state = ST_SKIP;
                        end
                    endcase
                end
            end
            ST_CONV: begin
                n_dig = {dab[DIG_W-2:0], r_bin[VALUE_BITS-1]};
                n_bin = r_bin << 1;
                if (r_cnt == CNT_W'(1)) begin
                    n_cnt   = CNT_W'(DEC_DIGITS);
                    n_state = ST_SKIP;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            ST_SKIP: begin
                if ((r_cnt > CNT_W'(1)) && (top == 4'd0)) begin
                    n_dig = dig_shift;
                    n_cnt = r_cnt - CNT_W'(1);
                end else begin
                    n_pad = gap;
                    if (r_neg) begin
                        n_state = ST_SIGN;
                    end else if (gap != '0) begin
                        n_state = ST_PAD;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    emit_char = CHAR_MINUS;
                    n_state   = (r_pad != '0) ? ST_PAD : ST_EMIT;
                end
            end
            ST_PAD: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    emit_char = CHAR_ZERO;
                    n_pad     = r_pad - PAD_W'(1);
                    if (r_pad == PAD_W'(1)) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    emit_char = digit_char(top);
                    emit_last = (r_cnt == CNT_W'(1));
                    n_dig     = dig_shift;
                    n_cnt     = r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_char  = emit_char;
            n_out_last  = emit_last;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dig      <= n_dig;
        r_bin      <= n_bin;
        r_cnt      <= n_cnt;
        r_pad      <= n_pad;
        r_neg      <= n_neg;
        r_bin_mode <= n_bin_mode;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_char};
    assign o_m_tlast  = r_out_last;

    a_emit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_cnt != '0))
        else $error("digit output with no digits left");

    a_pad_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAD) |-> (r_pad != '0))
        else $error("pad state with no pad zeros owed");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_last) |=> (r_state == ST_IDLE))
        else $error("engine not idle after last character");

    a_pop_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> ((r_state == ST_CONV) || (r_state == ST_SKIP)))
        else $error("command popped without starting conversion");

endmodule

// File: test/integer_to_text_formatter_checker.sv
// Checker for the integer to text formatter: predicts the text of each value and compares beats.
module integer_to_text_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // tdata: value [63:0], pad_width [70:64], zero [71]
    input  logic [itf_pkg::TDATA_IN_W-1:0]  i_s_tdata,
    // tuser: kind [1:0]
    input  logic [itf_pkg::KIND_W-1:0]      i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // tdata: text_char [6:0], zero [7]
    input  logic [itf_pkg::TDATA_OUT_W-1:0] i_m_tdata,
    input  logic                            i_m_tlast,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import itf_pkg::*;

    localparam int VALUE_BITS = VALUE_BITS_DEF;
    localparam int MAX_PAD    = MAX_PAD_DEF;
    localparam int MAX_CHARS  = 64;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last;
    } t_text_beat;

    t_text_beat expected_chars[$];
    int         mismatches = 0;

    function automatic logic [CHAR_W-1:0] nibble_char(input logic [3:0] d);
        if (d < 4'd10) begin
            return CHAR_ZERO + CHAR_W'(d);
        end
        return 7'h61 + CHAR_W'(d - 4'd10);
    endfunction

    // Build the text of one value and queue it, most significant character first.
    function automatic void predict_text(input t_kind kind, input logic [63:0] raw,
                                         input logic [PAD_IN_W-1:0] pad_in);
        logic [CHAR_W-1:0] text [MAX_CHARS];
        logic [CHAR_W-1:0] rev [24];
        logic [63:0]       mask;
        logic [63:0]       v;
        t_text_beat        beat;
        int                n;
        int                r;
        int                digits;
        int                total;
        int                pad;
        n    = 0;
        mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
        v    = raw & mask;
        pad  = int'(pad_in);
        case (kind)
            KIND_SDEC, KIND_UDEC: begin
                // magnitude is taken without sign, so the most negative value stays exact
                if (kind == KIND_SDEC && v[VALUE_BITS-1]) begin
                    text[n] = CHAR_MINUS;
                    n++;
                    v = (~v + 64'd1) & mask;
                end
                r = 0;
                rev[r] = CHAR_ZERO + CHAR_W'(v % 64'd10);
                r++;
                v = v / 64'd10;
                while (v != 64'd0) begin
                    rev[r] = CHAR_ZERO + CHAR_W'(v % 64'd10);
                    r++;
                    v = v / 64'd10;
                end
                while (r > 0) begin
                    r--;
                    text[n] = rev[r];
                    n++;
                end
            end
            KIND_HEX: begin
                digits = 1;
                while (digits < 16 && (v >> (4 * digits)) != 64'd0) begin
                    digits++;
                end
                if (pad > MAX_PAD) begin
                    pad = MAX_PAD;
                end
                total = (pad > digits) ? pad : digits;
                if (total > MAX_CHARS) begin
                    total = MAX_CHARS;
                end
                for (int i = 0; i < total - digits; i++) begin
                    text[n] = CHAR_ZERO;
                    n++;
                end
                for (int i = digits - 1; i >= 0 && n < MAX_CHARS; i--) begin
                    text[n] = nibble_char(4'((v >> (4 * i)) & 64'hf));
                    n++;
                end
            end
            default: begin
                digits = 1;
                while (digits < 64 && (v >> digits) != 64'd0) begin
                    digits++;
                end
                for (int i = digits - 1; i >= 0; i--) begin
                    text[n] = CHAR_ZERO + CHAR_W'(v[i]);
                    n++;
                end
            end
        endcase
        for (int k = 0; k < n; k++) begin
            beat.text_char = text[k];
            beat.last      = (k == n - 1);
            expected_chars.push_back(beat);
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_beat want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                predict_text(t_kind'(i_s_tuser), i_s_tdata[63:0], i_s_tdata[70:64]);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, got tdata %h tlast %b",
                             $time, i_m_tdata, i_m_tlast);
                    mismatches++;
                end else begin
                    want = expected_chars.pop_front();
                    if (i_m_tdata != {1'b0, want.text_char} || i_m_tlast != want.last) begin
                        $display("%0t: mismatch: expected tdata %h tlast %b, got tdata %h tlast %b",
                                 $time, {1'b0, want.text_char}, want.last, i_m_tdata, i_m_tlast);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_chars.size();
    end

endmodule

// File: test/testbench.sv
// Testbench top: stimulus, backpressure and verdict for the integer to text formatter.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import itf_pkg::*;

    // Longest stretch without any beat on either side before the run is called hung.
    // Worst legal case is the long output hold-off plus a few slow decimal conversions.
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 450;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // tdata: value [63:0], pad_width [70:64], zero [71]
    logic [TDATA_IN_W-1:0]  s_tdata = '0;
    // tuser: kind [1:0]
    logic [KIND_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // tdata: text_char [6:0], zero [7]
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tlast;

    int fail_count;
    int pending_chars;
    int idle_cycles = 0;

    // Shared between the stimulus and the receiver: burst phases drop all idling,
    // hold_req asks the receiver for one long hold-off.
    bit no_idle  = 1'b0;
    bit hold_req = 1'b0;

    always #5 i_clk = ~i_clk;

    integer_to_text_formatter_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    integer_to_text_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_chars)
    );

    // Watchdog: any beat on either channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, idle_cycles);
            $display("** integer_to_text_formatter_unit: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: per character a random wait, none in burst phases.
    // A hold-off request drops tready for a long stretch so the queue fills and
    // the input side has to stall.
    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
        end
    end

    // One input beat, after a random gap. tvalid is only lowered
    // when there is a gap, so back-to-back beats keep it high.
    task automatic send_value(input t_kind kind, input logic [63:0] value,
                              input logic [PAD_IN_W-1:0] pad);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, pad, value};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // Sender stops offering until every queued character has come out.
    task automatic drain_output();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_chars != 0);
    endtask

    // Random values with mixed shapes: full width, shortened, tiny, small negatives,
    // and patterns around the sign bit.
    function automatic logic [63:0] random_value();
        logic [63:0] full;
        full = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       return full;
            1:       return full >> $urandom_range(1, 63);
            2:       return 64'($urandom_range(0, 1000));
            3:       return -64'($urandom_range(1, 100000));
            4:       return {1'b1, 63'd0} | (full >> $urandom_range(8, 63));
            default: return {1'b0, {63{1'b1}}} >> $urandom_range(0, 62);
        endcase
    endfunction

    function automatic logic [PAD_IN_W-1:0] random_pad();
        if ($urandom_range(0, 7) == 0) begin
            return PAD_IN_W'($urandom_range(0, 127));
        end
        return PAD_IN_W'($urandom_range(0, 20));
    endfunction

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero and all ones on every kind, plus one and the sign-bit extremes.
        send_value(KIND_SDEC, 64'd0, 7'd0);
        send_value(KIND_UDEC, 64'd0, 7'd0);
        send_value(KIND_HEX,  64'd0, 7'd0);
        send_value(KIND_BIN,  64'd0, 7'd0);
        send_value(KIND_SDEC, 64'd1, 7'd0);
        send_value(KIND_BIN,  64'd1, 7'd0);
        send_value(KIND_BIN,  64'd2, 7'd0);
        send_value(KIND_SDEC, '1, 7'd0);                     // -1
        send_value(KIND_UDEC, '1, 7'd0);                     // top bit set, not negated
        send_value(KIND_HEX,  '1, 7'd0);
        send_value(KIND_BIN,  '1, 7'd0);                     // 64 characters
        send_value(KIND_SDEC, 64'h8000_0000_0000_0000, 7'd0); // most negative
        send_value(KIND_UDEC, 64'h8000_0000_0000_0000, 7'd0);
        send_value(KIND_SDEC, 64'h7fff_ffff_ffff_ffff, 7'd0);
        send_value(KIND_UDEC, 64'd10_000_000_000_000_000_000, 7'd0);
        send_value(KIND_UDEC, 64'd9, 7'd0);
        send_value(KIND_UDEC, 64'd10, 7'd0);
        // Hex padding: none, wider than the digits, at the cap, beyond the cap, too narrow.
        send_value(KIND_HEX,  64'h0123_4567_89ab_cdef, 7'd0);
        send_value(KIND_HEX,  64'h0, 7'd10);
        send_value(KIND_HEX,  64'hab, 7'd5);
        send_value(KIND_HEX,  64'hdead_beef, 7'd64);
        send_value(KIND_HEX,  64'h5, 7'd127);                // saturates to the cap
        send_value(KIND_HEX,  64'hfedc_ba98_7654_3210, 7'd1); // never cut
        // Pad width on other kinds is ignored.
        send_value(KIND_SDEC, -64'd42, 7'd30);
        send_value(KIND_BIN,  64'h5, 7'd127);

        // Random part with two long output hold-offs, a burst phase and drain pauses.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 100 || i == 330) begin
                hold_req = 1'b1;
            end
            if (i == 250 || i == 400) begin
                drain_output();
            end
            no_idle = (i >= 150 && i < 230);
            send_value(t_kind'($urandom_range(0, 3)), random_value(), random_pad());
        end
        no_idle = 1'b0;

        // Wait for the last characters, then a little longer for stray beats.
        drain_output();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending_chars == 0) begin
            $display("** integer_to_text_formatter_unit: PASSED **");
        end else begin
            $display("** integer_to_text_formatter_unit: FAILED **");
        end
        $finish;
    end

endmodule
